/* src/sur_pkg.sv */
// Package for the serial UTF-8 bit receiver: payload structs, configuration
// struct, event codes, register indexes and the UTF-8 lead byte decoder.
// No dependencies.
package sur_pkg;

  localparam int unsigned CountW = 24;
  localparam int unsigned RunW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [RunW-1:0]   RunMax   = {RunW{1'b1}};

  // Event codes of a result.
  localparam logic [2:0] EV_BYTE_OK = 3'd0;
  localparam logic [2:0] EV_NACK    = 3'd1;
  localparam logic [2:0] EV_RESTART = 3'd2;
  localparam logic [2:0] EV_RESET   = 3'd3;
  localparam logic [2:0] EV_EOM     = 3'd4;
  localparam logic [2:0] EV_IDLE    = 3'd5;

  // Input opcodes.
  localparam logic OP_BIT  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_RESET_RUN_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_LIMIT       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PURGE_TICKS      = 2'd2;

  localparam logic [RunW-1:0]   RESET_RUN_LENGTH_RST = 16'd16;
  localparam logic [CountW-1:0] IDLE_LIMIT_RST       = 24'd10000;
  localparam logic [CountW-1:0] PURGE_TICKS_RST      = 24'd4000;

  typedef struct packed {
    logic opcode;
    logic bit_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [7:0] data_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [RunW-1:0]   reset_run_length;
    logic [CountW-1:0] idle_limit;
    logic [CountW-1:0] purge_ticks;
  } cfg_t;

  // Sequence length announced by a lead byte, zero when it is no lead byte.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

/* src/sur_cfg.sv */
// Configuration register file of the serial UTF-8 bit receiver.
// Depends on sur_pkg for the configuration struct and register indexes.
module sur_cfg import sur_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RESET_RUN_LENGTH: cfg_d.reset_run_length = cfg_data_i[RunW-1:0];
        CFG_IDLE_LIMIT:       cfg_d.idle_limit       = cfg_data_i;
        CFG_PURGE_TICKS:      cfg_d.purge_ticks      = cfg_data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_run_length <= RESET_RUN_LENGTH_RST;
      cfg_q.idle_limit       <= IDLE_LIMIT_RST;
      cfg_q.purge_ticks      <= PURGE_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/sur_core.sv */
// Receiver core: input register, receiver state, per-item update logic and
// the result register. Depends on sur_pkg.
module sur_core import sur_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;

  logic [7:0]        shift_q, shift_d;
  logic [2:0]        pos_q, pos_d;
  logic [RunW-1:0]   ones_q, ones_d;
  logic [2:0]        expect_q, expect_d;
  logic [CountW-1:0] idle_q, idle_d;
  logic              purging_q, purging_d;
  logic [CountW-1:0] pcount_q, pcount_d;

  logic              res_valid;
  out_item_t         res;
  logic [CountW-1:0] pc_inc;
  logic [7:0]        shift_new;
  logic [RunW-1:0]   ones_new;
  logic [2:0]        lead_len;
  logic              bad_byte;

  // The result register is free when empty or drained in this cycle.
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    shift_d   = shift_q;
    pos_d     = pos_q;
    ones_d    = ones_q;
    expect_d  = expect_q;
    idle_d    = idle_q;
    purging_d = purging_q;
    pcount_d  = pcount_q;
    res_valid = 1'b0;
    res       = '0;
    pc_inc    = (pcount_q == CountMax) ? pcount_q : pcount_q + 1'b1;
    shift_new = s1_item_q.bit_value ? (shift_q | (8'd1 << pos_q)) : shift_q;
    ones_new  = s1_item_q.bit_value ? ((ones_q == RunMax) ? ones_q : ones_q + 1'b1)
                                    : '0;
    lead_len  = lead_length(shift_new);
    bad_byte  = (expect_q == 3'd0) ? (lead_len == 3'd0) : (shift_new[7:6] != 2'b10);

    if (s1_valid_q) begin
      if (s1_item_q.opcode == OP_TICK) begin
        if (purging_q) begin
          pcount_d = pc_inc;
          if (pc_inc >= cfg_i.purge_ticks) begin
            purging_d      = 1'b0;
            pcount_d       = '0;
            shift_d        = '0;
            pos_d          = 3'd7;
            res_valid      = 1'b1;
            res.event_code = EV_RESTART;
          end
        end else if (idle_q > cfg_i.idle_limit) begin
          shift_d        = '0;
          pos_d          = 3'd7;
          ones_d         = '0;
          idle_d         = '0;
          expect_d       = '0;
          pcount_d       = '0;
          res_valid      = 1'b1;
          res.event_code = EV_IDLE;
        end else if (idle_q != CountMax) begin
          idle_d = idle_q + 1'b1;
        end
      end else begin
        idle_d = '0;
        if (!purging_q) begin
          shift_d = shift_new;
          ones_d  = ones_new;
          if (cfg_i.reset_run_length != '0 && ones_new >= cfg_i.reset_run_length) begin
            shift_d        = '0;
            pos_d          = 3'd7;
            ones_d         = '0;
            expect_d       = '0;
            pcount_d       = '0;
            res_valid      = 1'b1;
            res.event_code = EV_RESET;
          end else if (pos_q != 3'd0) begin
            pos_d = pos_q - 1'b1;
          end else begin
            // A byte is complete; every outcome starts a fresh byte.
            shift_d = '0;
            pos_d   = 3'd7;
            if (shift_new == 8'hFF) begin
              res_valid = 1'b0;
            end else if (shift_new == 8'h00 && expect_q == 3'd0) begin
              ones_d         = '0;
              expect_d       = '0;
              pcount_d       = '0;
              res_valid      = 1'b1;
              res.event_code = EV_EOM;
              res.last       = 1'b1;
            end else if (bad_byte) begin
              purging_d      = 1'b1;
              pcount_d       = '0;
              res_valid      = 1'b1;
              res.event_code = EV_NACK;
            end else begin
              expect_d       = ((expect_q == 3'd0) ? lead_len : expect_q) - 1'b1;
              res_valid      = 1'b1;
              res.event_code = EV_BYTE_OK;
              res.data_byte  = shift_new;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      shift_q     <= '0;
      pos_q       <= 3'd7;
      ones_q      <= '0;
      expect_q    <= '0;
      idle_q      <= '0;
      purging_q   <= 1'b0;
      pcount_q    <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q && res_valid;
      end
      if (advance && s1_valid_q) begin
        shift_q   <= shift_d;
        pos_q     <= pos_d;
        ones_q    <= ones_d;
        expect_q  <= expect_d;
        idle_q    <= idle_d;
        purging_q <= purging_d;
        pcount_q  <= pcount_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

endmodule

/* src/serial_utf8_bit_receiver_top.sv */
// Serial UTF-8 bit receiver, top level. A result passes through the input
// register, then the result register, before it is valid.
// Throughput: one bit or tick per cycle, set by the state update between the
// two registers; a stalled result register holds the input side.
// Reset (rst_ni, asynchronous, active low) clears the receiver state and loads
// the register defaults 16, 10000 and 4000; no clearing pass is needed.
module serial_utf8_bit_receiver_top import sur_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i
);

  cfg_t cfg;

  sur_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sur_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for serial_utf8_bit_receiver_top: bit and tick traffic
// with random gaps and stalls, checked against a cycle-free model of the receiver.
// Depends on sur_pkg and the receiver RTL.
module tb_top import sur_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CountW-1:0]  cfg_data_i  = '0;

  serial_utf8_bit_receiver_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Receiver state as the model sees it, with its copy of the registers.
  logic [7:0]        rx_byte       = '0;
  logic [2:0]        rx_pos        = 3'd7;
  logic [RunW-1:0]   rx_ones       = '0;
  logic [2:0]        rx_pending    = '0;
  logic [CountW-1:0] rx_idle       = '0;
  logic              rx_purging    = 1'b0;
  logic [CountW-1:0] rx_purge      = '0;
  logic [RunW-1:0]   cfg_run_len   = RESET_RUN_LENGTH_RST;
  logic [CountW-1:0] cfg_idle_lim  = IDLE_LIMIT_RST;
  logic [CountW-1:0] cfg_purge_len = PURGE_TICKS_RST;

  out_item_t expected_events[$];
  out_item_t oldest_event;
  int        mismatch_count = 0;
  int        counted_items  = 0;
  int        cycle_count    = 0;
  bit        steady_mode    = 1'b0;
  bit        hold_results   = 1'b0;

  function automatic logic [2:0] utf8_seq_len(input logic [7:0] b);
    logic [2:0] len;
    casez (b)
      8'b0???????: len = 3'd1;
      8'b110?????: len = 3'd2;
      8'b1110????: len = 3'd3;
      8'b11110???: len = 3'd4;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic void clear_rx_session();
    rx_ones    = '0;
    rx_idle    = '0;
    rx_pending = '0;
    rx_purging = 1'b0;
    rx_purge   = '0;
  endfunction

  // Applies one bit or tick to the receiver state; returns 1 when it raises an event.
  function automatic bit advance_receiver(input in_item_t it, output out_item_t ev);
    logic [7:0] b;
    logic [2:0] len;
    ev = '0;
    if (it.opcode == OP_TICK) begin
      if (rx_purging) begin
        if (rx_purge != CountMax) rx_purge = rx_purge + 1'b1;
        if (rx_purge >= cfg_purge_len) begin
          rx_purging    = 1'b0;
          rx_purge      = '0;
          rx_byte       = '0;
          rx_pos        = 3'd7;
          ev.event_code = EV_RESTART;
          return 1'b1;
        end
        return 1'b0;
      end
      if (rx_idle > cfg_idle_lim) begin
        rx_byte = '0;
        rx_pos  = 3'd7;
        clear_rx_session();
        ev.event_code = EV_IDLE;
        return 1'b1;
      end
      if (rx_idle != CountMax) rx_idle = rx_idle + 1'b1;
      return 1'b0;
    end

    rx_idle = '0;
    if (rx_purging) return 1'b0;
    if (it.bit_value) begin
      rx_byte[rx_pos] = 1'b1;
      if (rx_ones != RunMax) rx_ones = rx_ones + 1'b1;
    end else begin
      rx_ones = '0;
    end
    if (cfg_run_len != '0 && rx_ones >= cfg_run_len) begin
      rx_byte = '0;
      rx_pos  = 3'd7;
      clear_rx_session();
      ev.event_code = EV_RESET;
      return 1'b1;
    end
    if (rx_pos != 3'd0) begin
      rx_pos = rx_pos - 1'b1;
      return 1'b0;
    end

    // A byte is complete; every outcome below starts the next byte afresh.
    b       = rx_byte;
    rx_byte = '0;
    rx_pos  = 3'd7;
    if (b == 8'hFF) return 1'b0;
    if (b == 8'h00 && rx_pending == 3'd0) begin
      clear_rx_session();
      ev.event_code = EV_EOM;
      ev.last       = 1'b1;
      return 1'b1;
    end
    len = utf8_seq_len(b);
    if ((rx_pending == 3'd0 && len == 3'd0) || (rx_pending != 3'd0 && b[7:6] != 2'b10)) begin
      rx_purging    = 1'b1;
      rx_purge      = '0;
      ev.event_code = EV_NACK;
      return 1'b1;
    end
    if (rx_pending == 3'd0) rx_pending = len;
    rx_pending    = rx_pending - 1'b1;
    ev.event_code = EV_BYTE_OK;
    ev.data_byte  = b;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady_mode || pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic op, input logic bit_val);
    in_item_t  it;
    out_item_t ev;
    int        gap;
    it.opcode    = op;
    it.bit_value = bit_val;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    // Bits offered during a purge are dropped by the block and are not counted.
    if (!(op == OP_BIT && rx_purging)) counted_items++;
    if (advance_receiver(it, ev)) expected_events.push_back(ev);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 1'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) send_item(OP_BIT, b[i]);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    // Items that raise no event may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] value);
    wait_for_drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_RESET_RUN_LENGTH: cfg_run_len   = value[RunW-1:0];
      CFG_IDLE_LIMIT:       cfg_idle_lim  = value;
      CFG_PURGE_TICKS:      cfg_purge_len = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [RunW-1:0] run_len, input logic [CountW-1:0] idle_lim,
                           input logic [CountW-1:0] purge_len);
    write_register(CFG_RESET_RUN_LENGTH, CountW'(run_len));
    write_register(CFG_IDLE_LIMIT, idle_lim);
    write_register(CFG_PURGE_TICKS, purge_len);
  endtask

  task automatic send_character();
    logic [7:0] r;
    int         len;
    r = 8'($urandom);
    if (rx_pending != 3'd0) begin
      send_byte({2'b10, r[5:0]});
    end else begin
      len = $urandom_range(1, 4);
      case (len)
        1:       send_byte((r[6:0] == 7'd0) ? 8'h41 : {1'b0, r[6:0]});
        2:       send_byte({3'b110, r[4:0]});
        3:       send_byte({4'b1110, r[3:0]});
        default: send_byte({5'b11110, r[2:0]});
      endcase
      for (int i = 1; i < len; i++) begin
        r = 8'($urandom);
        send_byte({2'b10, r[5:0]});
      end
    end
  endtask

  // Shortest cases: one-bit reset run, end of message, zero idle limit, nack and restart.
  task automatic test_directed_events();
    configure(16'd1, 24'd0, 24'd0);
    send_item(OP_BIT, 1'b1);
    send_byte(8'h00);
    send_tick();
    send_tick();
    write_register(CFG_RESET_RUN_LENGTH, CountW'(RESET_RUN_LENGTH_RST));
    send_byte(8'hC3);
    send_byte(8'h41);
    send_item(OP_BIT, 1'b1);
    send_tick();
  endtask

  // Largest purge and idle limits: no restart until the purge is shortened, and no idle timeout.
  task automatic test_purge_extremes();
    configure(16'd16, CountMax, CountMax);
    send_byte(8'h80);
    repeat (5) send_tick();
    send_item(OP_BIT, 1'b0);
    write_register(CFG_PURGE_TICKS, 24'd3);
    send_tick();
    repeat (20) send_tick();
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  // The result side stops for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    configure(16'd16, 24'd500, 24'd2);
    hold_results = 1'b1;
    wait (hold_results == 1'b0);
    steady_mode = 1'b1;
    repeat (8) send_character();
    send_byte(8'h00);
    steady_mode = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int target);
    int start;
    int pick;
    logic [7:0] r;
    start = counted_items;
    while (counted_items - start < target) begin
      if ($urandom_range(0, 19) == 0) steady_mode = !steady_mode;
      pick = $urandom_range(0, 99);
      if (pick < 52) begin
        send_character();
      end else if (pick < 60) begin
        while (rx_pending != 3'd0 && !rx_purging) send_character();
        send_byte(8'h00);
      end else if (pick < 68) begin
        repeat ($urandom_range(1, 8)) send_tick();
      end else if (pick < 74) begin
        repeat ((cfg_idle_lim <= 200) ? int'(cfg_idle_lim) + 2 : 5) send_tick();
      end else if (pick < 80) begin
        r = 8'($urandom);
        send_byte(r);
      end else if (pick < 85) begin
        send_byte(8'hFF);
      end else if (pick < 90) begin
        repeat ((cfg_run_len <= 64) ? int'(cfg_run_len) : 10) send_item(OP_BIT, 1'b1);
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 5)) send_item(1'($urandom), 1'($urandom));
      end else begin
        wait_for_drain();
      end
      // Leave the purge with ticks, now and then mixed with bits that are ignored.
      while (rx_purging) begin
        if ($urandom_range(0, 4) == 0) send_item(OP_BIT, 1'($urandom));
        else send_tick();
      end
    end
    steady_mode = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result: event_code %0d data_byte %0h last %0d",
               out_item_o.event_code, out_item_o.data_byte, out_item_o.last);
        mismatch_count++;
      end else begin
        oldest_event = expected_events.pop_front();
        if (out_item_o.event_code !== oldest_event.event_code) begin
          $error("event_code: expected %0d, actual %0d",
                 oldest_event.event_code, out_item_o.event_code);
          mismatch_count++;
        end
        if (out_item_o.data_byte !== oldest_event.data_byte) begin
          $error("data_byte: expected %0h, actual %0h",
                 oldest_event.data_byte, out_item_o.data_byte);
          mismatch_count++;
        end
        if (out_item_o.last !== oldest_event.last) begin
          $error("last: expected %0d, actual %0d", oldest_event.last, out_item_o.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : result_ready_gen
    int pick;
    int run;
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        hold_results = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else if (steady_mode) begin
        out_ready_i <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          out_ready_i <= 1'b1;
          run = $urandom_range(1, 8);
        end else begin
          out_ready_i <= 1'b0;
          if (pick < 90) run = $urandom_range(1, 3);
          else if (pick < 98) run = $urandom_range(4, 12);
          else run = $urandom_range(20, 60);
        end
        repeat (run - 1) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("serial_utf8_bit_receiver_top: mismatch");
    $finish;
  end

  initial begin : main_sequence
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_events();
    test_purge_extremes();
    test_backpressure();

    configure(16'd16, 24'($urandom_range(0, 40)), 24'($urandom_range(0, 20)));
    test_random_traffic(70);
    configure(16'($urandom_range(9, 30)), 24'($urandom_range(20, 200)),
              24'($urandom_range(1, 12)));
    test_random_traffic(60);
    configure(RunMax, 24'($urandom_range(0, 8)), 24'd0);
    test_random_traffic(50);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_events.size() != 0) begin
      $error("%0d expected results never arrived", expected_events.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("serial_utf8_bit_receiver_top: match");
    end else begin
      $display("serial_utf8_bit_receiver_top: mismatch");
    end
    $finish;
  end

endmodule
